### hdl/zwbc_pkg.sv
// shared types and constants for the zero-word block compressor
// used by every module of the block; depends on nothing

package zwbc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned ADDR_W = POS_W + 1;
  localparam int unsigned BLOCK_ELEMS_DEF = 32;
  localparam logic [DATA_W-1:0] FULL_TAG = 32'hFFFF_FFFF;

  // one closed block, as handed from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } desc_t;

  // buffer write from the front
  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } memwr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA
  } back_state_e;

endpackage

### hdl/zwbc_front.sv
// front of the compressor: accepts words, builds the tag, stores nonzero words
// depends on zwbc_pkg

module zwbc_front import zwbc_pkg::*; #(
  parameter int unsigned BLOCK_ELEMS = BLOCK_ELEMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_word_i,
  input  logic              in_last_i,
  input  logic              full_i,
  input  logic              wr_bank_i,
  output logic              push_o,
  output desc_t             desc_o,
  output memwr_t            memwr_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] tag_q, tag_d;
  logic acc, is_zero, close;
  logic [DATA_W-1:0] tag_next;
  logic [CNT_W-1:0] cnt_next;

  assign in_ready_o = !full_i;
  assign acc = in_valid_i && !full_i;
  assign is_zero = (in_word_i == '0);
  assign close = (pos_q == POS_W'(BLOCK_ELEMS - 1)) || in_last_i;

  assign tag_next = is_zero ? (tag_q & ~(DATA_W'(1) << pos_q)) : tag_q;
  assign cnt_next = is_zero ? cnt_q : cnt_q + CNT_W'(1);

  assign push_o = acc && close;
  assign desc_o.tag = tag_next;
  assign desc_o.cnt = cnt_next;

  assign memwr_o.en = acc && !is_zero;
  assign memwr_o.addr = {wr_bank_i, cnt_q[POS_W-1:0]};
  assign memwr_o.data = in_word_i;

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    tag_d = tag_q;
    if (acc) begin
      if (close) begin
        pos_d = '0;
        cnt_d = '0;
        tag_d = FULL_TAG;
      end else begin
        pos_d = pos_q + POS_W'(1);
        cnt_d = cnt_next;
        tag_d = tag_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      tag_q <= FULL_TAG;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      tag_q <= tag_d;
    end
  end

endmodule

### hdl/zwbc_queue.sv
// two-entry queue of closed blocks; its pointers also select the buffer bank
// depends on zwbc_pkg

module zwbc_queue import zwbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  head_valid_o,
  output desc_t head_o,
  output logic  head_bank_o,
  output logic  tail_bank_o
);

  desc_t ent_q [2];
  logic wr_ptr_q, wr_ptr_d;
  logic rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o = (fill_q == 2'd2);
  assign head_valid_o = (fill_q != 2'd0);
  assign head_o = ent_q[rd_ptr_q];
  assign head_bank_o = rd_ptr_q;
  assign tail_bank_o = wr_ptr_q;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

### hdl/zwbc_back.sv
// back of the compressor: holds the two-bank word buffer and emits tag and words
// depends on zwbc_pkg

module zwbc_back import zwbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  memwr_t            memwr_i,
  input  logic              head_valid_i,
  input  desc_t             head_i,
  input  logic              head_bank_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_word_o,
  output logic              out_is_tag_o,
  output logic              out_last_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_q;

  back_state_e state_q, state_d;
  logic [POS_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_word_q, out_word_d;
  logic out_is_tag_q, out_is_tag_d;
  logic out_last_q, out_last_d;
  logic slot_free, data_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign data_last = ((CNT_W'(idx_q) + CNT_W'(1)) == head_i.cnt);

  always_ff @(posedge clk_i) begin
    if (memwr_i.en) begin
      mem[memwr_i.addr] <= memwr_i.data;
    end
    rd_data_q <= mem[{head_bank_i, idx_q}];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i && slot_free && (head_i.cnt != '0)) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_DATA;
      BK_DATA: begin
        if (slot_free) begin
          state_d = data_last ? BK_IDLE : BK_READ;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o = 1'b0;
    idx_d = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d = out_word_q;
    out_is_tag_d = out_is_tag_q;
    out_last_d = out_last_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i && slot_free) begin
          out_valid_d = 1'b1;
          out_word_d = head_i.tag;
          out_is_tag_d = 1'b1;
          out_last_d = (head_i.cnt == '0);
          idx_d = '0;
          pop_o = (head_i.cnt == '0);
        end
      end
      BK_READ: begin
      end
      BK_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_word_d = rd_data_q;
          out_is_tag_d = 1'b0;
          out_last_d = data_last;
          pop_o = data_last;
          idx_d = idx_q + POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_is_tag_q <= out_is_tag_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;
  assign out_is_tag_o = out_is_tag_q;
  assign out_last_o = out_last_q;

endmodule

### hdl/zero_word_block_compressor.sv
// zero-word block compressor: one word accepted per cycle while a bank is free;
// a block closes on its BLOCK_ELEMS-th word or on in_last_i; its tag leaves through
// the queue and the output register, and each stored nonzero word then passes the
// buffer read register and then the output register.
// two buffer banks let the next block fill while the previous one drains.
// rst_ni clears all control state asynchronously; buffer contents are not reset.

module zero_word_block_compressor import zwbc_pkg::*; #(
  parameter int unsigned BLOCK_ELEMS = BLOCK_ELEMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_word_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_word_o,
  output logic              out_is_tag_o,
  output logic              out_last_o
);

  logic full, push, pop, head_valid, head_bank, tail_bank;
  desc_t desc, head;
  memwr_t memwr;

  zwbc_front #(.BLOCK_ELEMS(BLOCK_ELEMS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .wr_bank_i  (tail_bank),
    .push_o     (push),
    .desc_o     (desc),
    .memwr_o    (memwr)
  );

  zwbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_bank_o  (head_bank),
    .tail_bank_o  (tail_bank)
  );

  zwbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .memwr_i      (memwr),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_bank_i  (head_bank),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .out_is_tag_o (out_is_tag_o),
    .out_last_o   (out_last_o)
  );

endmodule

### hdl/zwbc_checker.sv
// port-level checks for the zero-word block compressor, bound to the top level
// depends on zwbc_pkg and zero_word_block_compressor

module zwbc_checker import zwbc_pkg::*; #(
  parameter int unsigned BLOCK_ELEMS = BLOCK_ELEMS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [DATA_W-1:0] in_word_i,
  input logic              in_last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] out_word_o,
  input logic              out_is_tag_o,
  input logic              out_last_o
);

  logic out_acc;
  logic expect_tag_q;
  logic [CNT_W-1:0] data_cnt_q;

  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_tag_q <= 1'b1;
      data_cnt_q <= '0;
    end else if (out_acc) begin
      expect_tag_q <= out_last_o;
      data_cnt_q <= out_last_o ? '0 : (out_is_tag_o ? '0 : data_cnt_q + CNT_W'(1));
    end
  end

  // a stalled input request keeps its word and flag
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i) && $stable(in_last_i))
    else $error("input request dropped or changed while stalled");

  // a pending result request holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o)
      && $stable(out_is_tag_o) && $stable(out_last_o))
    else $error("output request dropped or changed while stalled");

  // every run opens with exactly one tag
  a_tag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_is_tag_o == expect_tag_q))
    else $error("tag out of place in the output run");

  // only nonzero words follow the tag
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_is_tag_o |-> (out_word_o != '0))
    else $error("zero data word emitted");

  // no block emits more data words than it holds positions
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_is_tag_o |-> (data_cnt_q < CNT_W'(BLOCK_ELEMS)))
    else $error("too many data words in one block");

endmodule

bind zero_word_block_compressor zwbc_checker #(.BLOCK_ELEMS(BLOCK_ELEMS)) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .in_word_i    (in_word_i),
  .in_last_i    (in_last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_word_o   (out_word_o),
  .out_is_tag_o (out_is_tag_o),
  .out_last_o   (out_last_o)
);
